[rtl/path_obstacle_grid_inflation_defines.svh]
// Assertion macros used by the checker file of the grid inflation block.
// Depends on nothing; included by the checker by bare file name.
`ifndef PATH_OBSTACLE_GRID_INFLATION_DEFINES_SVH
`define PATH_OBSTACLE_GRID_INFLATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define POGI_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("grid inflation check failed");

// Next-cycle implication, disabled while reset is asserted
`define POGI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("grid inflation check failed");

`endif

[rtl/pogi_pkg.sv]
// Shared types, constants and helpers of the grid inflation block.
// No dependencies; imported by every module of the block.
package pogi_pkg;

	// Grid geometry
	localparam int GRID_WIDTH  = 256;
	localparam int GRID_HEIGHT = 256;
	localparam int GX_W        = $clog2(GRID_WIDTH);
	localparam int GY_W        = $clog2(GRID_HEIGHT);
	localparam int ADDR_W      = GX_W + GY_W;
	localparam int GRID_DEPTH  = 2 ** ADDR_W;

	// Field widths
	localparam int CELL_W  = 8;
	localparam int COORD_W = 8;
	localparam int PT_W    = 18;
	localparam int FRAC_W  = 8;
	localparam int REACH_W = 4;
	localparam int LIM_W   = 9;
	localparam int OFS_W   = REACH_W + 1;
	localparam int CRD_W   = 14;
	localparam int CTR_W   = PT_W - FRAC_W;

	// Signed cell coordinate (centers and scan positions)
	typedef logic signed [CRD_W-1:0] crd_t;

	localparam crd_t GRID_W_C = CRD_W'(GRID_WIDTH);
	localparam crd_t GRID_H_C = CRD_W'(GRID_HEIGHT);

	// Cell codes
	localparam logic signed [CELL_W-1:0] CELL_UNKNOWN = -8'sd1;
	localparam logic signed [CELL_W-1:0] CELL_OCC     = 8'sd1;
	localparam logic signed [CELL_W-1:0] CELL_FREE    = 8'sd0;

	// Request opcodes
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_STAMP = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic CFG_REACH = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	// Per-cycle output of the disk scanner
	typedef struct packed {
		logic              busy;
		logic              hit;
		logic              last;
		logic [ADDR_W-1:0] addr;
	} probe_t;

	function automatic logic in_grid(crd_t x, crd_t y);
		return !x[CRD_W-1] && !y[CRD_W-1] && (x < GRID_W_C) && (y < GRID_H_C);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(crd_t x, crd_t y);
		return {y[GY_W-1:0], x[GX_W-1:0]};
	endfunction

endpackage

[rtl/pogi_disk_scan.sv]
// Disk scanner: walks the (2*reach+1)^2 offsets around a center, one per cycle,
// and flags in-grid cells inside the squared-distance limit. Uses pogi_pkg.
module pogi_disk_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  pogi_pkg::crd_t             center_x,
	input  pogi_pkg::crd_t             center_y,
	input  logic [pogi_pkg::REACH_W-1:0] reach,
	input  logic [pogi_pkg::LIM_W-1:0] limit_sq,
	output pogi_pkg::probe_t           probe
);
	import pogi_pkg::*;

	logic                    busy_q;
	logic signed [OFS_W-1:0] dx_q, dy_q, r_q;
	crd_t                    cx_q, cy_q;

	logic signed [OFS_W-1:0]   r_new;
	logic signed [2*OFS_W-1:0] sqx, sqy;
	logic [LIM_W:0]            dist_sq;
	crd_t                      nx, ny;

	assign r_new = $signed({1'b0, reach});

	// Position and distance of the current offset
	assign nx      = cx_q + {{(CRD_W-OFS_W){dx_q[OFS_W-1]}}, dx_q};
	assign ny      = cy_q + {{(CRD_W-OFS_W){dy_q[OFS_W-1]}}, dy_q};
	assign sqx     = dx_q * dx_q;
	assign sqy     = dy_q * dy_q;
	assign dist_sq = {1'b0, sqx[LIM_W-1:0]} + {1'b0, sqy[LIM_W-1:0]};

	assign probe.busy = busy_q;
	assign probe.hit  = busy_q && in_grid(nx, ny) && (dist_sq <= {1'b0, limit_sq});
	assign probe.last = busy_q && (dx_q == r_q) && (dy_q == r_q);
	assign probe.addr = cell_addr(nx, ny);

	// Column-major offset walk (dy inner, dx outer); a start restarts the walk even on the last cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dx_q   <= '0;
			dy_q   <= '0;
			r_q    <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			dx_q   <= -r_new;
			dy_q   <= -r_new;
			r_q    <= r_new;
			cx_q   <= center_x;
			cy_q   <= center_y;
		end else if (busy_q) begin
			if (dy_q == r_q) begin
				dy_q <= -r_q;
				if (dx_q == r_q) begin
					busy_q <= 1'b0;
				end else begin
					dx_q <= dx_q + $signed(OFS_W'(1));
				end
			end else begin
				dy_q <= dy_q + $signed(OFS_W'(1));
			end
		end
	end

endmodule

[rtl/path_obstacle_grid_inflation.sv]
// Occupancy grid with obstacle inflation along waypoint paths (top level).
// Depends on pogi_pkg and pogi_disk_scan.
//
// Usage: one request channel (item_valid/item_ready) carries write-cell,
// read-cell and stamp-waypoint requests; one result channel
// (result_valid/result_ready) returns read_value for each read-cell request.
// Configuration (stamp_reach, stamp_limit_sq) is written through
// cfg_wr_en/cfg_addr/cfg_wdata while the block is idle.
// A write is stored at the edge on which it is accepted; a read result passes
// rdata_s1 and then the output register before it is offered, and the next
// request waits behind a read. A waypoint stamps one disk (a (2*reach+1)^2 scan),
// one cell per cycle, or two disks back to back (midpoint, then point) when it is
// not the first point of a path. The single grid memory port pair (one read, one
// write per cycle) sets the one-cell-per-cycle figure.
// Reset clears control state and the previous point; grid contents stay
// undefined until written, with no clearing pass. A stalled result waits in
// the output register; writes and stamps are still accepted behind it, a
// further read waits until the result is taken.
module path_obstacle_grid_inflation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [1:0]                          op,
	input  logic [pogi_pkg::COORD_W-1:0]        cell_x,
	input  logic [pogi_pkg::COORD_W-1:0]        cell_y,
	input  logic signed [pogi_pkg::CELL_W-1:0]  cell_value,
	input  logic signed [pogi_pkg::PT_W-1:0]    point_x,
	input  logic signed [pogi_pkg::PT_W-1:0]    point_y,
	input  logic                                path_start,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [pogi_pkg::CELL_W-1:0]  read_value,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_addr,
	input  logic [pogi_pkg::LIM_W-1:0]          cfg_wdata
);
	import pogi_pkg::*;

	op_t    op_in;
	logic   accept;
	probe_t probe;

	// Configuration registers
	logic [REACH_W-1:0] reach_q;
	logic [LIM_W-1:0]   limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= REACH_W'(3);
			limit_q <= LIM_W'(9);
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_REACH: reach_q <= cfg_wdata[REACH_W-1:0];
				CFG_LIMIT: limit_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	// Pipeline and output state
	logic                     stamp_s1, fwd_s1, rd_pend_s1, rd_inside_s1;
	logic [ADDR_W-1:0]        addr_s1;
	logic signed [CELL_W-1:0] rdata_s1, eff_s1;
	logic                     out_valid_q;
	logic signed [CELL_W-1:0] out_q;

	// Request acceptance: one request in flight; a read also needs the result slot
	assign op_in      = op_t'(op);
	assign item_ready = !probe.busy && !stamp_s1 && !rd_pend_s1 &&
		((op_in != OP_READ) || !out_valid_q || result_ready);
	assign accept     = item_valid && item_ready;

	// Host cell coordinates
	crd_t              hx, hy;
	logic              h_inside;
	logic [ADDR_W-1:0] h_addr;

	assign hx       = CRD_W'(cell_x);
	assign hy       = CRD_W'(cell_y);
	assign h_inside = in_grid(hx, hy);
	assign h_addr   = cell_addr(hx, hy);

	// Waypoint centers: floor(p/256) and floor((p+q)/512)
	logic signed [PT_W-1:0] prev_x_q, prev_y_q;
	logic signed [PT_W:0]   sum_x, sum_y;
	crd_t                   pt_cx, pt_cy, mid_cx, mid_cy;
	crd_t                   pt_cx_q, pt_cy_q;
	logic                   pt_pend_q;

	assign sum_x  = {point_x[PT_W-1], point_x} + {prev_x_q[PT_W-1], prev_x_q};
	assign sum_y  = {point_y[PT_W-1], point_y} + {prev_y_q[PT_W-1], prev_y_q};
	assign pt_cx  = {{(CRD_W-CTR_W){point_x[PT_W-1]}}, point_x[PT_W-1:FRAC_W]};
	assign pt_cy  = {{(CRD_W-CTR_W){point_y[PT_W-1]}}, point_y[PT_W-1:FRAC_W]};
	assign mid_cx = {{(CRD_W-CTR_W){sum_x[PT_W]}}, sum_x[PT_W:FRAC_W+1]};
	assign mid_cy = {{(CRD_W-CTR_W){sum_y[PT_W]}}, sum_y[PT_W:FRAC_W+1]};

	// Disk scans: midpoint disk, point disk right after; point only on path_start
	logic stamp_acc, second_disk, scan_start;
	crd_t scan_cx, scan_cy;

	assign stamp_acc   = accept && (op_in == OP_STAMP);
	assign second_disk = probe.last && pt_pend_q;
	assign scan_start  = stamp_acc || second_disk;

	always_comb begin
		if (second_disk) begin
			scan_cx = pt_cx_q;
			scan_cy = pt_cy_q;
		end else if (!path_start) begin
			scan_cx = mid_cx;
			scan_cy = mid_cy;
		end else begin
			scan_cx = pt_cx;
			scan_cy = pt_cy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			pt_pend_q <= 1'b0;
		end else if (stamp_acc) begin
			prev_x_q  <= point_x;
			prev_y_q  <= point_y;
			pt_pend_q <= !path_start;
		end else if (second_disk) begin
			pt_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stamp_acc) begin
			pt_cx_q <= pt_cx;
			pt_cy_q <= pt_cy;
		end
	end

	pogi_disk_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.center_x (scan_cx),
		.center_y (scan_cy),
		.reach    (reach_q),
		.limit_sq (limit_q),
		.probe    (probe)
	);

	// Read-modify-write: stamped cell reads are marked occupied unless unknown
	logic                     stamp_we, host_we, mem_we, host_re, mem_re;
	logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
	logic signed [CELL_W-1:0] mem_wdata;

	assign eff_s1    = fwd_s1 ? CELL_OCC : rdata_s1;
	assign stamp_we  = stamp_s1 && (eff_s1 != CELL_UNKNOWN);
	assign host_we   = accept && (op_in == OP_WRITE) && h_inside;
	assign mem_we    = stamp_we || host_we;
	assign mem_waddr = stamp_we ? addr_s1 : h_addr;
	assign mem_wdata = stamp_we ? CELL_OCC : cell_value;
	assign host_re   = accept && (op_in == OP_READ);
	assign mem_re    = host_re || probe.hit;
	assign mem_raddr = probe.hit ? probe.addr : h_addr;

	// Grid memory, one write and one registered read per cycle
	logic signed [CELL_W-1:0] grid_mem [GRID_DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= grid_mem[mem_raddr];
		end
	end

	// Stage 1 control; forward a write that lands on the cell read this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_s1   <= 1'b0;
			fwd_s1     <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			stamp_s1   <= probe.hit;
			fwd_s1     <= probe.hit && stamp_we && (probe.addr == addr_s1);
			rd_pend_s1 <= host_re;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1      <= probe.addr;
		rd_inside_s1 <= h_inside;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			out_q <= rd_inside_s1 ? eff_s1 : CELL_FREE;
		end
	end

	assign result_valid = out_valid_q;
	assign read_value   = out_q;

endmodule

[rtl/pogi_checker.sv]
// Port-level checks of the grid inflation block, bound to its top level.
// Depends on pogi_pkg and path_obstacle_grid_inflation_defines.svh.
`include "path_obstacle_grid_inflation_defines.svh"

module pogi_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic [1:0]                         op,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic signed [pogi_pkg::CELL_W-1:0] read_value
);
	import pogi_pkg::*;

	logic rd_acc, st_acc;

	assign rd_acc = item_valid && item_ready && (op == OP_READ);
	assign st_acc = item_valid && item_ready && (op == OP_STAMP);

	// A stalled result stays and holds its value
	`POGI_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid)
	`POGI_ASSERT_NEXT(a_value_held, clk, arst_n, result_valid && !result_ready, $stable(read_value))

	// Every accepted read returns its result after the read and output registers
	`POGI_ASSERT_NEXT(a_read_result, clk, arst_n, $past(rd_acc), result_valid)

	// A new result only appears after an accepted read has passed the read and output registers
	`POGI_ASSERT_NOW(a_no_spurious, clk, arst_n, $rose(result_valid), $past(rd_acc, 2))

	// A waypoint occupies the block: no request is taken in the next cycle
	`POGI_ASSERT_NEXT(a_stamp_busy, clk, arst_n, st_acc, !item_ready)

endmodule

bind path_obstacle_grid_inflation pogi_checker u_pogi_checker (.*);
